### rtl/hss_pkg.sv
// Shared types and constants for the half-step stepper sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hss_pkg;

	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_TICK  = 3'd1;
	localparam logic [2:0] OP_ENC_A = 3'd2;
	localparam logic [2:0] OP_ENC_B = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic       DIR_CW   = 1'b0;
	localparam logic [3:0] PHASE_FIRST = 4'd1;
	localparam logic [3:0] PHASE_LAST  = 4'd8;
	localparam logic [15:0] STEPS_MAX  = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] step_count;
		logic        move_direction;
		logic        a_level;
	} cmd_word_t;

	typedef struct packed {
		logic [3:0]  coils;
		logic [3:0]  phase;
		logic        busy_res;
		logic [15:0] steps_remaining;
		logic        warning;
		logic [15:0] total_pulse_count;
		logic        move_done;
	} res_word_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [15:0] steps_left;
		logic [15:0] cycle_pulses;
		logic [15:0] total_pulses;
		logic        commanded_dir;
		logic        sensed_dir;
		logic        busy;
		logic [3:0]  coil;
	} seq_state_t;

	function automatic logic [3:0] coil_of(input logic [3:0] phase);
		logic [2:0] idx;
		logic [3:0] pat;
		idx = 3'(phase - 4'd1);
		unique case (idx)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			default: pat = 4'h9;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

### rtl/hss_step.sv
// Next-state and result logic for one command word.
// Depends on hss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hss_step (
	input  wire hss_pkg::seq_state_t st,
	input  wire hss_pkg::cmd_word_t  cmd,
	output hss_pkg::seq_state_t      nx,
	output hss_pkg::res_word_t       res
);

	logic warn;
	logic done;
	logic abort;
	logic do_even;

	always_comb begin
		nx      = st;
		warn    = 1'b0;
		done    = 1'b0;
		abort   = 1'b0;
		do_even = 1'b0;
		unique case (cmd.opcode)
			hss_pkg::OP_START: begin
				nx.steps_left    = cmd.step_count;
				nx.commanded_dir = cmd.move_direction;
				nx.sensed_dir    = cmd.move_direction;
				nx.busy          = 1'b1;
				if (cmd.step_count == 16'd0) begin
					nx.busy = 1'b0;
					done    = 1'b1;
				end
			end
			hss_pkg::OP_TICK: begin
				if (st.busy) begin
					nx.coil = hss_pkg::coil_of(st.phase);
					if (st.commanded_dir == hss_pkg::DIR_CW) begin
						if (st.phase == hss_pkg::PHASE_LAST) begin
							nx.phase = hss_pkg::PHASE_FIRST;
							if (st.cycle_pulses == 16'd0) begin
								if (nx.steps_left != hss_pkg::STEPS_MAX)
									nx.steps_left = nx.steps_left + 16'd1;
								nx.coil  = hss_pkg::coil_of(hss_pkg::PHASE_FIRST);
								nx.phase = 4'd2;
							end else begin
								if (nx.steps_left != 16'd0)
									nx.steps_left = nx.steps_left - 16'd1;
								nx.cycle_pulses = 16'd0;
							end
						end else if (!st.phase[0]) begin
							do_even = 1'b1;
						end else begin
							nx.phase = st.phase + 4'd1;
						end
					end else begin
						if (st.phase == hss_pkg::PHASE_FIRST) begin
							nx.phase = hss_pkg::PHASE_LAST;
							if (st.cycle_pulses == 16'd0) begin
								if (nx.steps_left != hss_pkg::STEPS_MAX)
									nx.steps_left = nx.steps_left + 16'd1;
								nx.coil = hss_pkg::coil_of(hss_pkg::PHASE_LAST);
								do_even = 1'b1;
							end else begin
								nx.cycle_pulses = 16'd0;
							end
						end else if (!st.phase[0]) begin
							do_even = 1'b1;
						end else begin
							nx.phase = st.phase - 4'd1;
						end
					end
					if (do_even) begin
						if (st.commanded_dir == hss_pkg::DIR_CW)
							nx.phase = nx.phase + 4'd1;
						else
							nx.phase = nx.phase - 4'd1;
						if (nx.steps_left != 16'd0)
							nx.steps_left = nx.steps_left - 16'd1;
						if (st.sensed_dir != st.commanded_dir) begin
							abort = 1'b1;
							if (st.commanded_dir == hss_pkg::DIR_CW)
								nx.phase = (nx.phase <= 4'd2) ? nx.phase + 4'd6
									: nx.phase - 4'd2;
							else
								nx.phase = (nx.phase >= 4'd7) ? nx.phase - 4'd6
									: nx.phase + 4'd2;
						end
					end
					if (abort) begin
						nx.busy = 1'b0;
						warn    = 1'b1;
						done    = 1'b1;
					end else if (nx.steps_left == 16'd0) begin
						nx.busy = 1'b0;
						done    = 1'b1;
					end
				end
			end
			hss_pkg::OP_ENC_A: begin
				nx.cycle_pulses = st.cycle_pulses + 16'd1;
				nx.total_pulses = st.total_pulses + 16'd1;
			end
			hss_pkg::OP_ENC_B: begin
				nx.sensed_dir = ~cmd.a_level;
			end
			hss_pkg::OP_CLEAR: begin
				nx.total_pulses = 16'd0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.coils             = nx.coil;
		res.phase             = nx.phase;
		res.busy_res          = nx.busy;
		res.steps_remaining   = nx.steps_left;
		res.warning           = warn;
		res.total_pulse_count = nx.total_pulses;
		res.move_done         = done;
	end

endmodule

`default_nettype wire

### rtl/half_step_stepper_sequencer_top.sv
// A command word is registered in the input stage, then in the result register.
// One word per cycle when not stalled; state updates as words leave the input stage.
// The input stage advances whenever the result register is empty or being taken.
// Reset: phase 1, coils off, counts zero, idle; both stages empty.
// Holds the input stage, sequencer state and result register; uses hss_pkg, hss_step.
`timescale 1ns / 1ps
`default_nettype none

module half_step_stepper_sequencer_top (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cmd_valid,
	output logic                   cmd_ready,
	input  wire hss_pkg::cmd_word_t cmd,
	output logic                   res_valid,
	input  wire                    res_ready,
	output hss_pkg::res_word_t     res
);

	hss_pkg::cmd_word_t  cmd_s1;
	logic                cmd_valid_s1;
	hss_pkg::seq_state_t st_q;
	hss_pkg::seq_state_t st_nx;
	hss_pkg::res_word_t  res_nx;
	hss_pkg::res_word_t  res_q;
	logic                res_valid_q;
	logic                adv;

	assign adv       = cmd_valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !cmd_valid_s1 || adv;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	hss_step u_step (
		.st  (st_q),
		.cmd (cmd_s1),
		.nx  (st_nx),
		.res (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid)
			cmd_s1 <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase         <= hss_pkg::PHASE_FIRST;
			st_q.steps_left    <= 16'd0;
			st_q.cycle_pulses  <= 16'd0;
			st_q.total_pulses  <= 16'd0;
			st_q.commanded_dir <= 1'b0;
			st_q.sensed_dir    <= 1'b0;
			st_q.busy          <= 1'b0;
			st_q.coil          <= 4'd0;
			res_valid_q        <= 1'b0;
		end else begin
			if (adv)
				st_q <= st_nx;
			if (adv)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_nx;
	end

endmodule

`default_nettype wire

### rtl/hss_checker.sv
// Port-level checks for the sequencer top, bound to every instance.
// Depends on hss_pkg and half_step_stepper_sequencer_top.
`timescale 1ns / 1ps
`default_nettype none

module hss_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     res_valid,
	input wire                     res_ready,
	input wire hss_pkg::res_word_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped before it was taken");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res))
		else $error("result word changed while stalled");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.phase >= 4'd1 && res.phase <= 4'd8))
		else $error("phase out of range");

	a_warn_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.warning |-> res.move_done && !res.busy_res)
		else $error("warning without end of move");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.move_done |-> !res.busy_res)
		else $error("move done while still busy");

endmodule

bind half_step_stepper_sequencer_top hss_checker u_hss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

`default_nettype wire

### verif/tb.sv
// Self-checking bench for half_step_stepper_sequencer_top: random and directed command words,
// results checked against an in-bench model of the half-step sequencer.
// Depends on hss_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

	localparam int LIMIT = 4_000_000;
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	hss_pkg::cmd_word_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	hss_pkg::res_word_t res;

	half_step_stepper_sequencer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #5 clk = ~clk;

	hss_pkg::cmd_word_t cmd_backlog[$];
	hss_pkg::res_word_t motor_reports[$];
	hss_pkg::res_word_t want;
	int errs = 0;
	int n_results = 0;
	int cycle_cnt = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int hold_left = 0;
	logic hold_taken = 1'b0;
	logic calm;

	assign calm = (cycle_cnt[9:8] == 2'b00);

	// sequencer model state
	logic [3:0]  ph_m = hss_pkg::PHASE_FIRST;
	logic [15:0] left_m = '0;
	logic [15:0] cyc_m = '0;
	logic [15:0] total_m = '0;
	logic        dir_m = hss_pkg::DIR_CW;
	logic        sense_m = hss_pkg::DIR_CW;
	logic        busy_m = 1'b0;
	logic [3:0]  coil_m = '0;

	function automatic logic [3:0] coil_for(input logic [3:0] ph);
		case (ph)
			4'd1: return 4'h1;
			4'd2: return 4'h3;
			4'd3: return 4'h2;
			4'd4: return 4'h6;
			4'd5: return 4'h4;
			4'd6: return 4'hC;
			4'd7: return 4'h8;
			default: return 4'h9;
		endcase
	endfunction

	function automatic bit full_step();
		if (dir_m == hss_pkg::DIR_CW)
			ph_m = ph_m + 4'd1;
		else
			ph_m = ph_m - 4'd1;
		if (left_m != 16'd0)
			left_m = left_m - 16'd1;
		if (sense_m != dir_m) begin
			if (dir_m == hss_pkg::DIR_CW)
				ph_m = (ph_m <= 4'd2) ? ph_m + 4'd6 : ph_m - 4'd2;
			else
				ph_m = (ph_m >= 4'd7) ? ph_m - 4'd6 : ph_m + 4'd2;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit tick_motor();
		coil_m = coil_for(ph_m);
		if (dir_m == hss_pkg::DIR_CW) begin
			if (ph_m == hss_pkg::PHASE_LAST) begin
				ph_m = hss_pkg::PHASE_FIRST;
				if (cyc_m == 16'd0) begin
					if (left_m != hss_pkg::STEPS_MAX)
						left_m = left_m + 16'd1;
					coil_m = coil_for(ph_m);
					ph_m = 4'd2;
				end else begin
					if (left_m != 16'd0)
						left_m = left_m - 16'd1;
					cyc_m = '0;
				end
			end else if (!ph_m[0]) begin
				return full_step();
			end else begin
				ph_m = ph_m + 4'd1;
			end
		end else begin
			if (ph_m == hss_pkg::PHASE_FIRST) begin
				ph_m = hss_pkg::PHASE_LAST;
				if (cyc_m == 16'd0) begin
					if (left_m != hss_pkg::STEPS_MAX)
						left_m = left_m + 16'd1;
					coil_m = coil_for(ph_m);
					return full_step();
				end
				cyc_m = '0;
			end else if (!ph_m[0]) begin
				return full_step();
			end else begin
				ph_m = ph_m - 4'd1;
			end
		end
		return 1'b0;
	endfunction

	function automatic hss_pkg::res_word_t step_sequencer(input hss_pkg::cmd_word_t w);
		hss_pkg::res_word_t r;
		logic warn;
		logic done;
		warn = 1'b0;
		done = 1'b0;
		case (w.opcode)
			hss_pkg::OP_START: begin
				left_m = w.step_count;
				dir_m = w.move_direction;
				sense_m = w.move_direction;
				busy_m = 1'b1;
				if (left_m == 16'd0) begin
					busy_m = 1'b0;
					done = 1'b1;
				end
			end
			hss_pkg::OP_TICK: begin
				if (busy_m) begin
					if (tick_motor()) begin
						busy_m = 1'b0;
						warn = 1'b1;
						done = 1'b1;
					end else if (left_m == 16'd0) begin
						busy_m = 1'b0;
						done = 1'b1;
					end
				end
			end
			hss_pkg::OP_ENC_A: begin
				cyc_m = cyc_m + 16'd1;
				total_m = total_m + 16'd1;
			end
			hss_pkg::OP_ENC_B: sense_m = w.a_level ? hss_pkg::DIR_CW : ~hss_pkg::DIR_CW;
			hss_pkg::OP_CLEAR: total_m = '0;
			default: ;
		endcase
		r.coils = coil_m;
		r.phase = ph_m;
		r.busy_res = busy_m;
		r.steps_remaining = left_m;
		r.warning = warn;
		r.total_pulse_count = total_m;
		r.move_done = done;
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic hss_pkg::cmd_word_t rand_word(input logic [2:0] op);
		hss_pkg::cmd_word_t w;
		w.opcode = op;
		w.step_count = 16'($urandom_range(0, 65535));
		w.move_direction = 1'($urandom_range(0, 1));
		w.a_level = 1'($urandom_range(0, 1));
		return w;
	endfunction

	function automatic hss_pkg::cmd_word_t start_word(input logic [15:0] n, input logic d);
		hss_pkg::cmd_word_t w;
		w = rand_word(hss_pkg::OP_START);
		w.step_count = n;
		w.move_direction = d;
		return w;
	endfunction

	// one move: start, then ticks mixed with encoder edges at a per-move pulse rate, clears and random words
	task automatic push_move();
		logic dir;
		int pa;
		int k;
		hss_pkg::cmd_word_t w;
		dir = 1'($urandom_range(0, 1));
		pa = $urandom_range(0, 30);
		if ($urandom_range(0, 9) == 0)
			cmd_backlog.push_back(start_word(16'($urandom_range(0, 65535)), dir));
		else
			cmd_backlog.push_back(start_word(16'($urandom_range(0, 12)), dir));
		repeat ($urandom_range(4, 48)) begin
			k = $urandom_range(0, 99);
			if (k < pa) begin
				w = rand_word(hss_pkg::OP_ENC_A);
			end else if (k < pa + 55) begin
				w = rand_word(hss_pkg::OP_TICK);
			end else if (k < pa + 65) begin
				w = rand_word(hss_pkg::OP_ENC_B);
				if ($urandom_range(0, 5) != 0)
					w.a_level = (dir == hss_pkg::DIR_CW);
			end else if (k < pa + 68) begin
				w = rand_word(hss_pkg::OP_CLEAR);
			end else if (k < pa + 70) begin
				w = rand_word(3'($urandom_range(0, 7)));
			end else begin
				w = rand_word(hss_pkg::OP_TICK);
			end
			cmd_backlog.push_back(w);
		end
	endtask

	initial begin
		hss_pkg::cmd_word_t w;
		cmd_backlog.push_back(rand_word(hss_pkg::OP_CLEAR));
		cmd_backlog.push_back(rand_word(hss_pkg::OP_TICK));
		cmd_backlog.push_back(start_word(16'd0, hss_pkg::DIR_CW));
		for (int i = OP_UNUSED_LO; i <= OP_UNUSED_HI; i++)
			cmd_backlog.push_back(rand_word(3'(i)));
		// walk to phase 8, then restart with the largest count and wrap with no pulses
		cmd_backlog.push_back(start_word(16'd7, hss_pkg::DIR_CW));
		repeat (7) cmd_backlog.push_back(rand_word(hss_pkg::OP_TICK));
		cmd_backlog.push_back(start_word(hss_pkg::STEPS_MAX, hss_pkg::DIR_CW));
		cmd_backlog.push_back(rand_word(hss_pkg::OP_TICK));
		repeat (2) cmd_backlog.push_back(rand_word(hss_pkg::OP_ENC_A));
		// sense the wrong way, then abort on the next full step
		w = rand_word(hss_pkg::OP_ENC_B);
		w.a_level = 1'b0;
		cmd_backlog.push_back(w);
		cmd_backlog.push_back(rand_word(hss_pkg::OP_TICK));
		// counterclockwise wrap with pulses, run to completion
		cmd_backlog.push_back(start_word(16'd2, ~hss_pkg::DIR_CW));
		repeat (4) cmd_backlog.push_back(rand_word(hss_pkg::OP_TICK));

		while (cmd_backlog.size() < 700) begin
			if ($urandom_range(0, 9) < 8)
				push_move();
			else
				repeat ($urandom_range(1, 4))
					cmd_backlog.push_back(rand_word(3'($urandom_range(0, 7))));
		end
		repeat (4) push_move();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (cmd_backlog.size() != 0 || cmd_valid || motor_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errs == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			tx_gap <= 0;
		end else begin
			if (cmd_valid && cmd_ready)
				motor_reports.push_back(step_sequencer(cmd));
			if (!cmd_valid || cmd_ready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					cmd_valid <= 1'b0;
				end else if (cmd_backlog.size() != 0) begin
					cmd <= cmd_backlog.pop_front();
					cmd_valid <= 1'b1;
					tx_gap <= (!calm && $urandom_range(0, 2) == 0) ? gap_len() : 0;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stalls; one long hold lets the block back up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			rx_gap <= 0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (!hold_taken && cycle_cnt >= 300) begin
			hold_taken <= 1'b1;
			hold_left <= 300;
			res_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			res_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			rx_gap <= gap_len();
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			n_results++;
			if (motor_reports.size() == 0) begin
				errs++;
				if (errs <= 10)
					$display("tb: result %0d arrived with nothing expected", n_results);
			end else begin
				want = motor_reports.pop_front();
				if (res.coils !== want.coils || res.phase !== want.phase
						|| res.busy_res !== want.busy_res
						|| res.steps_remaining !== want.steps_remaining
						|| res.warning !== want.warning
						|| res.total_pulse_count !== want.total_pulse_count
						|| res.move_done !== want.move_done) begin
					errs++;
					if (errs <= 10)
						$display({"tb: result %0d exp coils=%h ph=%0d busy=%b left=%0d warn=%b ",
							"total=%0d done=%b | got coils=%h ph=%0d busy=%b left=%0d warn=%b ",
							"total=%0d done=%b"}, n_results,
							want.coils, want.phase, want.busy_res, want.steps_remaining,
							want.warning, want.total_pulse_count, want.move_done,
							res.coils, res.phase, res.busy_res, res.steps_remaining,
							res.warning, res.total_pulse_count, res.move_done);
				end
			end
		end
	end

endmodule

### filelist.f
rtl/hss_pkg.sv
rtl/hss_step.sv
rtl/half_step_stepper_sequencer_top.sv
rtl/hss_checker.sv
verif/tb.sv
